// ===== src/rfcg_pkg.sv =====
// ----------------------------------------------------------------------------
// rfcg_pkg
// shared types and constants of the rectangle fill command generator
// ----------------------------------------------------------------------------
package rfcg_pkg;

  // fixed field widths
  localparam int FIELD_W  = 16;
  localparam int COORD_W  = 8;
  localparam int BYTE_W   = 8;
  localparam int ROT_W    = 2;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_ROTATION = 1'b0;

  // parameter defaults
  localparam int PANEL_WIDTH_DEF  = 130;
  localparam int PANEL_HEIGHT_DEF = 130;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // controller commands
  localparam logic [BYTE_W-1:0] CMD_WIN_H   = 8'h44;
  localparam logic [BYTE_W-1:0] CMD_WIN_V   = 8'h45;
  localparam logic [BYTE_W-1:0] CMD_ADDR    = 8'h21;
  localparam logic [BYTE_W-1:0] CMD_WR_DATA = 8'h22;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_COLOR = 2'd2
  } kind_t;

  // one clipped rectangle ready for the sequencer
  typedef struct packed {
    logic [5:0][BYTE_W-1:0] win_bytes;
    logic [FIELD_W-1:0]     color;
    logic [FIELD_W-1:0]     area;
  } cmd_entry_t;

endpackage

// ===== src/rfcg_rect_if.sv =====
// ----------------------------------------------------------------------------
// rfcg_rect_if
// rectangle channel: valid/ready handshake with origin, spans and color
// ----------------------------------------------------------------------------
interface rfcg_rect_if
  import rfcg_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] left;
  logic signed [FIELD_W-1:0] top;
  logic signed [FIELD_W-1:0] span_x;
  logic signed [FIELD_W-1:0] span_y;
  logic        [FIELD_W-1:0] fill_color;

  modport source (output valid, left, top, span_x, span_y, fill_color, input ready);
  modport sink   (input valid, left, top, span_x, span_y, fill_color, output ready);
endinterface

// ===== src/rfcg_res_if.sv =====
// ----------------------------------------------------------------------------
// rfcg_res_if
// result channel: valid/ready handshake with one command, data or color item
// ----------------------------------------------------------------------------
interface rfcg_res_if
  import rfcg_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [FIELD_W-1:0] value;
  logic [FIELD_W-1:0] repeat_res;
  logic               last;

  modport source (output valid, kind, value, repeat_res, last, input ready);
  modport sink   (input valid, kind, value, repeat_res, last, output ready);
endinterface

// ===== src/rfcg_front.sv =====
// ----------------------------------------------------------------------------
// rfcg_front
// clips incoming rectangles, drops empty ones, builds window bytes and area
// ----------------------------------------------------------------------------
module rfcg_front
  import rfcg_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ROT_W-1:0] rotation,
  rfcg_rect_if.sink        rect,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_entry_t       push_data
);

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;

  localparam logic [BYTE_W-1:0] PW8 = BYTE_W'(PANEL_WIDTH);
  localparam logic [BYTE_W-1:0] PH8 = BYTE_W'(PANEL_HEIGHT);

  logic signed [17:0] lx, ty, ex, ey;
  logic signed [17:0] lxc, tyc, exc, eyc;
  logic signed [17:0] vis_w, vis_h;
  logic               empty;
  logic               accept;

  logic               s1_valid_r, s1_valid_nxt;
  logic [COORD_W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [FIELD_W-1:0] color_r;
  logic [ROT_W-1:0]   rot_r;

  logic [BYTE_W-1:0]  x1b, y1b, x2b, y2b;
  logic [COORD_W-1:0] span_w, span_h;

  // clip in 18 bits so ends never wrap
  always_comb begin
    vis_w = rotation[0] ? 18'(PANEL_HEIGHT) : 18'(PANEL_WIDTH);
    vis_h = rotation[0] ? 18'(PANEL_WIDTH)  : 18'(PANEL_HEIGHT);
    lx    = {{2{rect.left[FIELD_W-1]}}, rect.left};
    ty    = {{2{rect.top[FIELD_W-1]}}, rect.top};
    ex    = lx + {{2{rect.span_x[FIELD_W-1]}}, rect.span_x};
    ey    = ty + {{2{rect.span_y[FIELD_W-1]}}, rect.span_y};
    lxc   = (lx < 0) ? '0 : lx;
    tyc   = (ty < 0) ? '0 : ty;
    exc   = (ex > vis_w) ? vis_w : ex;
    eyc   = (ey > vis_h) ? vis_h : ey;
    empty = (exc <= lxc) || (eyc <= tyc);
  end

  assign rect.ready = !s1_valid_r || push_ready;
  assign accept     = rect.valid && rect.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = !empty;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r    <= lxc[COORD_W-1:0];
      y1_r    <= tyc[COORD_W-1:0];
      x2_r    <= COORD_W'(exc - 18'sd1);
      y2_r    <= COORD_W'(eyc - 18'sd1);
      color_r <= rect.fill_color;
      rot_r   <= rotation;
    end
  end

  // address bytes per rotation, all mod 256
  always_comb begin
    x1b    = BYTE_W'(x1_r);
    y1b    = BYTE_W'(y1_r);
    x2b    = BYTE_W'(x2_r);
    y2b    = BYTE_W'(y2_r);
    span_w = x2_r - x1_r + COORD_W'(1);
    span_h = y2_r - y1_r + COORD_W'(1);
    push_data.color = color_r;
    push_data.area  = FIELD_W'(span_w) * FIELD_W'(span_h);
    case (rot_r)
      ROT_0: begin
        push_data.win_bytes[0] = x2b + 8'd2;
        push_data.win_bytes[1] = x1b + 8'd2;
        push_data.win_bytes[2] = y2b + 8'd2;
        push_data.win_bytes[3] = y1b + 8'd2;
        push_data.win_bytes[4] = y1b + 8'd2;
        push_data.win_bytes[5] = x1b + 8'd2;
      end
      ROT_90: begin
        push_data.win_bytes[0] = PH8 - y1b + 8'd1;
        push_data.win_bytes[1] = PH8 - y2b + 8'd1;
        push_data.win_bytes[2] = PW8 - x1b - 8'd1;
        push_data.win_bytes[3] = PW8 - x2b - 8'd1;
        push_data.win_bytes[4] = PW8 - x1b - 8'd1;
        push_data.win_bytes[5] = PH8 - y1b + 8'd1;
      end
      ROT_180: begin
        push_data.win_bytes[0] = PW8 - x1b + 8'd1;
        push_data.win_bytes[1] = PW8 - x2b + 8'd1;
        push_data.win_bytes[2] = PH8 - y1b + 8'd1;
        push_data.win_bytes[3] = PH8 - y2b + 8'd1;
        push_data.win_bytes[4] = PH8 - y1b + 8'd1;
        push_data.win_bytes[5] = PW8 - x1b + 8'd1;
      end
      default: begin
        push_data.win_bytes[0] = y2b + 8'd2;
        push_data.win_bytes[1] = y1b + 8'd2;
        push_data.win_bytes[2] = x2b;
        push_data.win_bytes[3] = x1b;
        push_data.win_bytes[4] = x1b;
        push_data.win_bytes[5] = y1b + 8'd2;
      end
    endcase
  end

  assign push_valid = s1_valid_r;

endmodule

// ===== src/rfcg_queue.sv =====
// ----------------------------------------------------------------------------
// rfcg_queue
// small fifo of clipped rectangles between the front end and the sequencer
// ----------------------------------------------------------------------------
module rfcg_queue
  import rfcg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  cmd_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output cmd_entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_entry_t         slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // wrap explicitly so non power of two depths work too
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/rfcg_seq.sv =====
// ----------------------------------------------------------------------------
// rfcg_seq
// steps through the eleven results of one rectangle into the output register
// ----------------------------------------------------------------------------
module rfcg_seq
  import rfcg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cmd_entry_t pop_data,
  rfcg_res_if.source res
);

  typedef enum logic [10:0] {
    STEP_WIN_H   = 11'b000_0000_0001,
    STEP_WIN_H0  = 11'b000_0000_0010,
    STEP_WIN_H1  = 11'b000_0000_0100,
    STEP_WIN_V   = 11'b000_0000_1000,
    STEP_WIN_V0  = 11'b000_0001_0000,
    STEP_WIN_V1  = 11'b000_0010_0000,
    STEP_ADDR    = 11'b000_0100_0000,
    STEP_ADDR0   = 11'b000_1000_0000,
    STEP_ADDR1   = 11'b001_0000_0000,
    STEP_WR_DATA = 11'b010_0000_0000,
    STEP_COLOR   = 11'b100_0000_0000
  } step_t;

  cmd_entry_t         cur_r;
  logic               busy_r, busy_nxt;
  step_t              step_r, step_nxt;
  step_t              step_adv;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r;
  logic [FIELD_W-1:0] out_value_r, out_repeat_r;
  logic               out_last_r;

  logic               out_free, emit, load;
  kind_t              kind;
  logic [FIELD_W-1:0] value;
  logic [FIELD_W-1:0] rep;
  logic               last;

  assign out_free  = !out_valid_r || res.ready;
  assign emit      = busy_r && out_free;
  // next rectangle loads in the same cycle the color result goes out
  assign pop_ready = !busy_r || (emit && (step_r == STEP_COLOR));
  assign load      = pop_valid && pop_ready;

  always_comb begin
    kind     = KIND_DATA;
    value    = '0;
    rep      = FIELD_W'(1);
    last     = 1'b0;
    step_adv = STEP_WIN_H;
    case (step_r)
      STEP_WIN_H: begin
        kind     = KIND_CMD;
        value    = FIELD_W'(CMD_WIN_H);
        step_adv = STEP_WIN_H0;
      end
      STEP_WIN_H0: begin
        value    = FIELD_W'(cur_r.win_bytes[0]);
        step_adv = STEP_WIN_H1;
      end
      STEP_WIN_H1: begin
        value    = FIELD_W'(cur_r.win_bytes[1]);
        step_adv = STEP_WIN_V;
      end
      STEP_WIN_V: begin
        kind     = KIND_CMD;
        value    = FIELD_W'(CMD_WIN_V);
        step_adv = STEP_WIN_V0;
      end
      STEP_WIN_V0: begin
        value    = FIELD_W'(cur_r.win_bytes[2]);
        step_adv = STEP_WIN_V1;
      end
      STEP_WIN_V1: begin
        value    = FIELD_W'(cur_r.win_bytes[3]);
        step_adv = STEP_ADDR;
      end
      STEP_ADDR: begin
        kind     = KIND_CMD;
        value    = FIELD_W'(CMD_ADDR);
        step_adv = STEP_ADDR0;
      end
      STEP_ADDR0: begin
        value    = FIELD_W'(cur_r.win_bytes[4]);
        step_adv = STEP_ADDR1;
      end
      STEP_ADDR1: begin
        value    = FIELD_W'(cur_r.win_bytes[5]);
        step_adv = STEP_WR_DATA;
      end
      STEP_WR_DATA: begin
        kind     = KIND_CMD;
        value    = FIELD_W'(CMD_WR_DATA);
        step_adv = STEP_COLOR;
      end
      STEP_COLOR: begin
        kind     = KIND_COLOR;
        value    = cur_r.color;
        rep      = cur_r.area;
        last     = 1'b1;
        step_adv = STEP_WIN_H;
      end
      default: begin
        kind     = KIND_DATA;
        value    = '0;
        step_adv = STEP_WIN_H;
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !res.ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (step_r == STEP_COLOR) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_adv;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_WIN_H;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_WIN_H;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= pop_data;
    end
    if (emit) begin
      out_kind_r   <= kind;
      out_value_r  <= value;
      out_repeat_r <= rep;
      out_last_r   <= last;
    end
  end

  assign res.valid      = out_valid_r;
  assign res.kind       = out_kind_r;
  assign res.value      = out_value_r;
  assign res.repeat_res = out_repeat_r;
  assign res.last       = out_last_r;

endmodule

// ===== src/lcd_rect_fill_command_gen_core.sv =====
// ----------------------------------------------------------------------------
// lcd_rect_fill_command_gen_core
// turns fill rectangles into window, address and write-data command sequences
//
//   channel   dir  handshake        payload
//   in_rect   in   valid/ready      left, top, span_x, span_y, fill_color
//   out_res   out  valid/ready      kind, value, repeat_res, last
//   cfg       in   apb write/read   rotation at byte address 0
//
// a non-empty rectangle gives eleven results, one per cycle from the
// sequencer while the result side is ready, and the next rectangle loads
// as the color result goes out; empty ones are dropped in the front end.
// results pass the clip register, the queue, cur_r and the output register.
// front end and sequencer are split by a small queue and stall independently.
// reset is synchronous, active low; rotation resets to 0.
// ----------------------------------------------------------------------------
module lcd_rect_fill_command_gen_core
  import rfcg_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rfcg_rect_if.sink             in_rect,
  rfcg_res_if.source            out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ROT_W-1:0] rotation_r, rotation_nxt;
  logic             reg_sel;

  logic             push_valid, push_ready;
  cmd_entry_t       push_data;
  logic             pop_valid, pop_ready;
  cmd_entry_t       pop_data;

  // register index is the word address
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_ROTATION);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DATA_W'(rotation_r) : '0;

  always_comb begin
    rotation_nxt = rotation_r;
    if (psel && penable && pwrite && reg_sel) begin
      rotation_nxt = pwdata[ROT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= '0;
    end else begin
      rotation_r <= rotation_nxt;
    end
  end

  rfcg_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .rotation   (rotation_r),
    .rect       (in_rect),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rfcg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rfcg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res       (out_res)
  );

endmodule

// ===== sim/lcd_rect_fill_command_gen_core_tb.sv =====
// ----------------------------------------------------------------------------
// lcd_rect_fill_command_gen_core_tb
// self-checking bench for the rectangle fill command generator
//
// drives rectangles on the input channel and writes the rotation register.
// an in-bench predictor clips each rectangle to the panel and queues the
// eleven command, data and color results. each result transaction is then
// checked field by field against the oldest queued one. both handshakes
// stall at random, the result side is held off for a long stretch once,
// and the run closes with a drain and a settle window.
// ----------------------------------------------------------------------------
module lcd_rect_fill_command_gen_core_tb;
  import rfcg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_W       = PANEL_WIDTH_DEF;
  localparam int PANEL_H       = PANEL_HEIGHT_DEF;
  localparam int IDLE_PCT      = 35;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 200000;

  localparam logic [CFG_ADDR_W-1:0] ADDR_ROTATION = {REG_ROTATION, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE    = {1'b1, 2'b00};

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic signed [FIELD_W-1:0] left;
    logic signed [FIELD_W-1:0] top;
    logic signed [FIELD_W-1:0] span_x;
    logic signed [FIELD_W-1:0] span_y;
    logic        [FIELD_W-1:0] fill_color;
  } rect_t;

  typedef struct {
    kind_t              kind;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] reps;
    logic               last;
  } res_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rfcg_rect_if rect_if ();
  rfcg_res_if  res_if ();

  res_item_t        pending_results[$];
  logic [ROT_W-1:0] rot_q = ROT_0;
  logic             no_idle = 1'b0;
  logic             sink_hold = 1'b0;
  int               filled_rects = 0;
  int               mismatches = 0;
  int               cycle_count = 0;
  event             hold_go;

  lcd_rect_fill_command_gen_core #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rect(rect_if),
    .out_res(res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // clip to the rotated panel and queue the command sequence, if any
  function automatic bit predict_fill_sequence(rect_t r);
    int lx, ty, ex, ey, vis_w, vis_h, x1, y1, x2, y2, area;
    int wb[6];
    logic [BYTE_W-1:0] cmds[3];
    vis_w = rot_q[0] ? PANEL_H : PANEL_W;
    vis_h = rot_q[0] ? PANEL_W : PANEL_H;
    lx = int'(r.left);
    ty = int'(r.top);
    ex = lx + int'(r.span_x);
    ey = ty + int'(r.span_y);
    if (lx < 0) lx = 0;
    if (ty < 0) ty = 0;
    if (ex > vis_w) ex = vis_w;
    if (ey > vis_h) ey = vis_h;
    if (ex <= lx || ey <= ty) return 1'b0;
    x1 = lx;
    y1 = ty;
    x2 = ex - 1;
    y2 = ey - 1;
    case (rot_q)
      ROT_0:   wb = '{x2 + 2, x1 + 2, y2 + 2, y1 + 2, y1 + 2, x1 + 2};
      ROT_90:  wb = '{PANEL_H - y1 + 1, PANEL_H - y2 + 1, PANEL_W - x1 - 1,
                      PANEL_W - x2 - 1, PANEL_W - x1 - 1, PANEL_H - y1 + 1};
      ROT_180: wb = '{PANEL_W - x1 + 1, PANEL_W - x2 + 1, PANEL_H - y1 + 1,
                      PANEL_H - y2 + 1, PANEL_H - y1 + 1, PANEL_W - x1 + 1};
      default: wb = '{y2 + 2, y1 + 2, x2, x1, x1, y1 + 2};
    endcase
    cmds = '{CMD_WIN_H, CMD_WIN_V, CMD_ADDR};
    for (int i = 0; i < 3; i++) begin
      pending_results.push_back('{KIND_CMD, {8'h00, cmds[i]}, 16'd1, 1'b0});
      pending_results.push_back('{KIND_DATA, 16'(wb[2*i] & 'hFF), 16'd1, 1'b0});
      pending_results.push_back('{KIND_DATA, 16'(wb[2*i+1] & 'hFF), 16'd1, 1'b0});
    end
    pending_results.push_back('{KIND_CMD, {8'h00, CMD_WR_DATA}, 16'd1, 1'b0});
    area = (x2 - x1 + 1) * (y2 - y1 + 1);
    pending_results.push_back('{KIND_COLOR, r.fill_color, 16'(area), 1'b1});
    return 1'b1;
  endfunction

  function automatic rect_t mk_rect(int l, int t, int sx, int sy, int col);
    rect_t r;
    r.left       = 16'(l);
    r.top        = 16'(t);
    r.span_x     = 16'(sx);
    r.span_y     = 16'(sy);
    r.fill_color = 16'(col);
    return r;
  endfunction

  // always lands on the panel
  function automatic rect_t good_rect();
    int sx, sy;
    sx = ($urandom_range(3) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 16);
    sy = ($urandom_range(3) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 16);
    return mk_rect($urandom_range(0, 129), $urandom_range(0, 129), sx, sy, $urandom);
  endfunction

  function automatic rect_t random_rect();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return good_rect();
    if (pick < 85)
      return mk_rect(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                     int'($urandom_range(0, 400)) - 100, int'($urandom_range(0, 400)) - 100,
                     $urandom);
    return mk_rect($urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_rect(rect_t r);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        rect_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    rect_if.valid      <= 1'b1;
    rect_if.left       <= r.left;
    rect_if.top        <= r.top;
    rect_if.span_x     <= r.span_x;
    rect_if.span_y     <= r.span_y;
    rect_if.fill_color <= r.fill_color;
    do @(posedge clk); while (!rect_if.ready);
    if (predict_fill_sequence(r)) filled_rects++;
  endtask

  task automatic drain_results();
    rect_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ROTATION) rot_q = data[ROT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_rotation_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ROTATION;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ROT_W-1:0] !== rot_q)
      report_mismatch("rotation readback", 32'(prdata[ROT_W-1:0]), 32'(rot_q));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // the block must be idle, empty rectangles may still be in flight
  task automatic set_rotation(logic [ROT_W-1:0] rot);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(ADDR_ROTATION, {30'($urandom), rot});
    check_rotation_reg();
  endtask

  // result side: random stalls, forced low during a hold-off
  always @(posedge clk)
    res_if.ready <= !sink_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);

  always begin
    @(hold_go);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    res_item_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(res_if.value), '0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.kind !== want.kind)
          report_mismatch("kind", 32'(res_if.kind), 32'(want.kind));
        if (res_if.value !== want.value)
          report_mismatch("value", 32'(res_if.value), 32'(want.value));
        if (res_if.repeat_res !== want.reps)
          report_mismatch("repeat_res", 32'(res_if.repeat_res), 32'(want.reps));
        if (res_if.last !== want.last)
          report_mismatch("last", 32'(res_if.last), 32'(want.last));
      end
    end
  end

  // rotation 0 straight out of reset: borders, clipping, empty cases
  task automatic test_edge_rects();
    check_rotation_reg();
    send_rect(mk_rect(0, 0, PANEL_W, PANEL_H, 'hFFFF));
    send_rect(mk_rect(0, 0, 1, 1, 'h0000));
    send_rect(mk_rect(PANEL_W - 1, PANEL_H - 1, 1, 1, 'h1234));
    send_rect(mk_rect(-5, -7, 10, 12, 'hA5A5));
    send_rect(mk_rect(120, 125, 50, 50, 'h5A5A));
    send_rect(mk_rect(-100, -100, 32767, 32767, 'h7FFF));
    send_rect(mk_rect(0, 0, 0, 5, 'h0F0F));
    send_rect(mk_rect(0, 0, 5, -1, 'hF0F0));
    send_rect(mk_rect(PANEL_W, 0, 5, 5, 'h8001));
    // negative extent that would wrap to zero in 16 bits stays empty
    send_rect(mk_rect(-32768, -32768, -32768, -32768, 'hFFFF));
    send_rect(mk_rect(32767, 32767, 32767, 32767, 'h0000));
    send_rect(mk_rect(-32768, 0, 32767, 10, 'h1111));
    send_rect(mk_rect(-1, -1, 2, 2, 'h2222));
    send_rect(mk_rect(0, 64, PANEL_W, 1, 'h8000));
  endtask

  task automatic test_rotations();
    for (int r = 1; r < 4; r++) begin
      set_rotation(r[ROT_W-1:0]);
      send_rect(mk_rect(0, 0, PANEL_W, PANEL_H, 'hFFFF));
      send_rect(mk_rect(3, 5, 7, 9, 'h4321));
      send_rect(mk_rect(-2, 100, 10, 50, 'h00FF));
    end
  endtask

  task automatic test_spare_address();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(ADDR_SPARE, $urandom);
    check_rotation_reg();
    send_rect(mk_rect(10, 20, 3, 4, 'hBEEF));
  endtask

  task automatic test_backpressure();
    drain_results();
    no_idle <= 1'b1;
    -> hold_go;
    repeat (12) send_rect(good_rect());
    drain_results();
    no_idle <= 1'b0;
  endtask

  task automatic test_sender_pause();
    repeat (6) send_rect(good_rect());
    drain_results();
    repeat (6) send_rect(good_rect());
  endtask

  task automatic test_steady_stream();
    int start;
    set_rotation(ROT_180);
    no_idle <= 1'b1;
    start = filled_rects;
    while (filled_rects - start < 30) send_rect(random_rect());
    drain_results();
    no_idle <= 1'b0;
  endtask

  task automatic test_random_mix();
    int start;
    logic [ROT_W-1:0] order[4];
    order = '{ROT_270, ROT_0, ROT_90, ROT_180};
    foreach (order[k]) begin
      set_rotation(order[k]);
      start = filled_rects;
      while (filled_rects - start < 28) send_rect(random_rect());
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    rect_if.valid      <= 1'b0;
    rect_if.left       <= '0;
    rect_if.top        <= '0;
    rect_if.span_x     <= '0;
    rect_if.span_y     <= '0;
    rect_if.fill_color <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_rects();
    test_rotations();
    test_spare_address();
    test_backpressure();
    test_sender_pause();
    test_steady_stream();
    test_random_mix();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
